>>> design/per_key_keyboard_debounce_core_macros.svh
// Assertion macros shared by the debounce core.
`ifndef PER_KEY_KEYBOARD_DEBOUNCE_CORE_MACROS_SVH
`define PER_KEY_KEYBOARD_DEBOUNCE_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KDB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kdb: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define KDB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kdb: next-cycle check failed");

`endif

>>> design/kdb_pkg.sv
// Types and constants shared by the per-key debounce modules.
package kdb_pkg;

    localparam int KEY_W    = 10;
    localparam int TS_W     = 63;
    localparam int WIN_W    = 9;
    localparam int SLOT_W   = 20;
    localparam int WIN_NS_W = 29;
    localparam int CFG_IDX_W = 3;

    typedef logic [TS_W-1:0]     ts_t;
    typedef logic [KEY_W-1:0]    key_t;
    typedef logic [WIN_W-1:0]    win_t;
    typedef logic [SLOT_W-1:0]   slot_t;
    typedef logic [WIN_NS_W-1:0] win_ns_t;

    localparam win_t    MAX_MS     = 9'd500;
    localparam win_t    DEFAULT_MS = 9'd0;
    localparam win_ns_t NS_PER_MS  = 29'd1000000;
    localparam ts_t     STALE_NS   = 63'd5000000000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GWIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT0  = 3'd2;
    localparam int                   CFG_SLOT_REGS = 4;

    // Slot field positions.
    localparam int SLOT_VALID_BIT = 19;
    localparam int SLOT_CODE_LSB  = 9;

    // Per-key flags, event bit lowest.
    typedef struct packed {
        logic rel;
        logic prs;
        logic held;
        logic ev;
    } key_flags_t;

    // Per-key timestamps kept in one memory row.
    typedef struct packed {
        ts_t event_t;
        ts_t release_t;
        ts_t press_t;
    } time_row_t;

    // Decision for one item: what to write back and what to report.
    typedef struct packed {
        logic       drop;
        logic       wr_en;
        key_flags_t flags;
        time_row_t  times;
        logic       acc_valid;
        key_t       acc_code;
    } judge_t;

    // Windows above the limit fall back to the default.
    function automatic win_t sane_window(input win_t ms);
        sane_window = (ms > MAX_MS) ? DEFAULT_MS : ms;
    endfunction

endpackage

>>> design/kdb_ram.sv
// Generic single-write, single-read memory with a registered read port.
module kdb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port; a same-address read returns old data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/kdb_window.sv
// Window lookup: first matching override slot, else the global window, in ns.
module kdb_window
    import kdb_pkg::*;
#(
    parameter int SLOTS = 4
) (
    input  key_t    code,
    input  slot_t   slots [SLOTS],
    input  win_t    global_win,
    output win_ns_t win_ns
);

    win_t sel;

    // Walk from the last slot down so that the lowest matching slot wins.
    always_comb
    begin
        sel = sane_window(global_win);
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (slots[i][SLOT_VALID_BIT] &&
                slots[i][SLOT_CODE_LSB +: KEY_W] == code)
            begin
                sel = sane_window(slots[i][WIN_W-1:0]);
            end
        end
    end

    assign win_ns = WIN_NS_W'(sel) * NS_PER_MS;

endmodule

>>> design/kdb_judge.sv
// Per-item debounce decision and the updated per-key state.
module kdb_judge
    import kdb_pkg::*;
(
    input  logic       enable,
    input  logic       in_range,
    input  key_t       code,
    input  logic       pressed,
    input  logic       repeated,
    input  ts_t        ts,
    input  win_ns_t    win_ns,
    input  key_flags_t flags,
    input  time_row_t  times,
    input  logic       acc_valid,
    input  key_t       acc_code,
    output judge_t     res
);

    logic       stale;
    logic       press_hit;
    logic       rel_hit;
    logic       acc_after;
    logic       acc_match;
    key_flags_t fa;
    ts_t        win_ts;

    assign win_ts    = TS_W'(win_ns);
    assign acc_match = acc_valid && (acc_code == code);

    // Timestamp went backwards or the key sat idle too long.
    assign stale = flags.ev &&
                   ((ts < times.event_t) || ((ts - times.event_t) > STALE_NS));
    assign fa        = stale ? key_flags_t'('0) : flags;
    assign acc_after = acc_valid && !(stale && acc_code == code);

    // Distance checks against the last press and last release.
    assign press_hit = (ts >= times.press_t) && ((ts - times.press_t) < win_ts);
    assign rel_hit   = (ts >= times.release_t) && ((ts - times.release_t) < win_ts);

    always_comb
    begin
        res.drop      = 1'b0;
        res.wr_en     = 1'b0;
        res.flags     = flags;
        res.times     = times;
        res.acc_valid = acc_valid;
        res.acc_code  = acc_code;
        if (!in_range)
        begin
            // Codes beyond the store pass and touch nothing.
        end
        else if (!enable)
        begin
            res.wr_en     = 1'b1;
            res.flags     = '0;
            res.acc_valid = acc_valid && !acc_match;
        end
        else
        begin
            res.wr_en     = 1'b1;
            res.flags     = fa;
            res.acc_valid = acc_after;
            if (!pressed)
            begin
                if (fa.held)
                begin
                    res.flags.held      = 1'b0;
                    res.flags.rel       = 1'b1;
                    res.times.release_t = ts;
                end
            end
            else if (repeated)
            begin
                res.flags.held = 1'b1;
            end
            else if (win_ns != '0 && fa.held && fa.prs && press_hit)
            begin
                res.drop = 1'b1;
            end
            else if (win_ns != '0 && fa.rel && acc_after && acc_code == code && rel_hit)
            begin
                res.drop = 1'b1;
            end
            else
            begin
                res.flags.held    = 1'b1;
                res.flags.prs     = 1'b1;
                res.times.press_t = ts;
                res.acc_valid     = 1'b1;
                res.acc_code      = code;
            end
            res.flags.ev      = 1'b1;
            res.times.event_t = ts;
        end
    end

endmodule

>>> design/per_key_keyboard_debounce_core.sv
// Pipeline: the accepting edge loads the read stage, which reads the key's memory rows; the
// decision stage judges the item and loads the output register once that register is free.
// Throughput: one item per cycle unless the output stalls; a flag memory and a time memory
// are read on accept and written back when the item retires, with forwarding when the same
// key follows directly. Reset: control and configuration clear at once, then a pass clears
// the per-key flag memory; no item is accepted during that pass, config writes are taken.
module per_key_keyboard_debounce_core
    import kdb_pkg::*;
#(
    parameter int KEY_COUNT      = 1024,
    parameter int OVERRIDE_SLOTS = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // Input stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [79:0]          s_tdata,   // event_code[9:0], time_ns[72:10], zero fill
    input  logic [1:0]           s_tuser,   // key_pressed[0], auto_repeat[1]
    // Result stream.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // drops_total[31:0]
    output logic [0:0]           m_tuser,   // drop_event[0]
    // Configuration writes.
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SLOT_W-1:0]    cfg_wdata
);

`include "per_key_keyboard_debounce_core_macros.svh"

    localparam int AW = $clog2(KEY_COUNT);
    localparam int FLAG_W = $bits(key_flags_t);
    localparam int TIME_W = $bits(time_row_t);

    // Input fields.
    key_t    s_code;
    ts_t     s_ts;
    logic    s_in_range;
    logic    accept;
    logic    fire;
    win_ns_t s_win_ns;

    assign s_code     = s_tdata[KEY_W-1:0];
    assign s_ts       = s_tdata[KEY_W +: TS_W];
    assign s_in_range = {1'b0, s_code} < (KEY_W + 1)'(KEY_COUNT);

    // Configuration registers.
    logic  enable_reg;
    win_t  gwin_reg;
    slot_t slot_reg [OVERRIDE_SLOTS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            gwin_reg   <= '0;
            for (int i = 0; i < OVERRIDE_SLOTS; i++)
            begin
                slot_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_ENABLE)
            begin
                enable_reg <= cfg_wdata[0];
            end
            if (cfg_index == CFG_GWIN)
            begin
                gwin_reg <= sane_window(cfg_wdata[WIN_W-1:0]);
            end
            for (int i = 0; i < OVERRIDE_SLOTS; i++)
            begin
                if (i < CFG_SLOT_REGS && cfg_index == CFG_SLOT0 + CFG_IDX_W'(i))
                begin
                    slot_reg[i] <= cfg_wdata;
                end
            end
        end
    end

    // Window for the incoming key, registered with the item.
    kdb_window #(
        .SLOTS(OVERRIDE_SLOTS)
    ) u_window (
        .code      (s_code),
        .slots     (slot_reg),
        .global_win(gwin_reg),
        .win_ns    (s_win_ns)
    );

    // Flag memory clearing pass after reset.
    logic          clr_active_reg;
    logic          clr_active_next;
    logic [AW-1:0] clr_addr_reg;
    logic [AW-1:0] clr_addr_next;

    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            if (clr_addr_reg == AW'(KEY_COUNT - 1))
            begin
                clr_active_next = 1'b0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + AW'(1);
            end
        end
    end

    // Stage registers holding the item whose memory row is being read.
    logic       p1_valid_reg;
    logic       p1_valid_next;
    logic       p1_inr_reg;
    key_t       p1_code_reg;
    logic       p1_pressed_reg;
    logic       p1_repeat_reg;
    ts_t        p1_ts_reg;
    win_ns_t    p1_win_reg;
    logic       fwd_valid_reg;
    logic       fwd_valid_next;
    key_flags_t fwd_flags_reg;
    time_row_t  fwd_times_reg;

    // Output register and the state kept across items.
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       m_drop_reg;
    logic [31:0] m_drops_reg;
    logic       acc_valid_reg;
    key_t       acc_code_reg;
    logic [31:0] drop_cnt_reg;
    logic [31:0] drop_cnt_next;

    judge_t     jdg;
    key_flags_t rd_flags;
    time_row_t  rd_times;
    key_flags_t cur_flags;
    time_row_t  cur_times;
    logic [FLAG_W-1:0] flag_rdata;
    logic [TIME_W-1:0] time_rdata;
    logic              flag_we;
    logic [AW-1:0]     flag_waddr;
    logic [FLAG_W-1:0] flag_wdata;
    logic              time_we;

    // Handshake: the decision stage retires when the output register is free.
    assign fire     = p1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !clr_active_reg && (!p1_valid_reg || fire);
    assign accept   = s_tvalid && s_tready;

    // A write of the same key as the item being accepted is registered and forwarded to that item.
    assign fwd_valid_next = accept ? (fire && jdg.wr_en && s_code == p1_code_reg)
                                   : fwd_valid_reg;
    assign p1_valid_next  = accept || (p1_valid_reg && !fire);
    assign m_valid_next   = fire || (m_valid_reg && !m_tready);
    assign drop_cnt_next  = drop_cnt_reg + 32'(jdg.drop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            p1_valid_reg   <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
            acc_valid_reg  <= 1'b0;
            acc_code_reg   <= '0;
            drop_cnt_reg   <= '0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            p1_valid_reg   <= p1_valid_next;
            fwd_valid_reg  <= fwd_valid_next;
            m_valid_reg    <= m_valid_next;
            if (fire)
            begin
                acc_valid_reg <= jdg.acc_valid;
                acc_code_reg  <= jdg.acc_code;
                drop_cnt_reg  <= drop_cnt_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_inr_reg     <= s_in_range;
            p1_code_reg    <= s_code;
            p1_pressed_reg <= s_tuser[0];
            p1_repeat_reg  <= s_tuser[1];
            p1_ts_reg      <= s_ts;
            p1_win_reg     <= s_win_ns;
            fwd_flags_reg  <= jdg.flags;
            fwd_times_reg  <= jdg.times;
        end
        if (fire)
        begin
            m_drop_reg  <= jdg.drop;
            m_drops_reg <= drop_cnt_next;
        end
    end

    // Per-key memories.
    assign flag_we    = clr_active_reg || (fire && jdg.wr_en);
    assign flag_waddr = clr_active_reg ? clr_addr_reg : p1_code_reg[AW-1:0];
    assign flag_wdata = clr_active_reg ? '0 : jdg.flags;
    assign time_we    = fire && jdg.wr_en;

    kdb_ram #(
        .WIDTH(FLAG_W),
        .DEPTH(KEY_COUNT)
    ) u_flag_ram (
        .clk  (clk),
        .we   (flag_we),
        .waddr(flag_waddr),
        .wdata(flag_wdata),
        .re   (accept),
        .raddr(s_code[AW-1:0]),
        .rdata(flag_rdata)
    );

    kdb_ram #(
        .WIDTH(TIME_W),
        .DEPTH(KEY_COUNT)
    ) u_time_ram (
        .clk  (clk),
        .we   (time_we),
        .waddr(p1_code_reg[AW-1:0]),
        .wdata(jdg.times),
        .re   (accept),
        .raddr(s_code[AW-1:0]),
        .rdata(time_rdata)
    );

    assign rd_flags  = key_flags_t'(flag_rdata);
    assign rd_times  = time_row_t'(time_rdata);
    assign cur_flags = fwd_valid_reg ? fwd_flags_reg : rd_flags;
    assign cur_times = fwd_valid_reg ? fwd_times_reg : rd_times;

    // Decision for the item in the read stage.
    kdb_judge u_judge (
        .enable   (enable_reg),
        .in_range (p1_inr_reg),
        .code     (p1_code_reg),
        .pressed  (p1_pressed_reg),
        .repeated (p1_repeat_reg),
        .ts       (p1_ts_reg),
        .win_ns   (p1_win_reg),
        .flags    (cur_flags),
        .times    (cur_times),
        .acc_valid(acc_valid_reg),
        .acc_code (acc_code_reg),
        .res      (jdg)
    );

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_drops_reg;
    assign m_tuser[0] = m_drop_reg;

    // Checks on the pipeline and the counter.
    `KDB_ASSERT_SAME(a_no_accept_clearing, clk, rst_n, clr_active_reg, !s_tready)
    `KDB_ASSERT_SAME(a_release_never_dropped, clk, rst_n, fire && !p1_pressed_reg, !jdg.drop)
    `KDB_ASSERT_NEXT(a_count_on_drop, clk, rst_n, fire && jdg.drop,
        drop_cnt_reg == $past(drop_cnt_reg) + 32'd1)

endmodule

>>> test/testbench.sv
// Self-checking testbench for the per-key keyboard debounce core.
`timescale 1ns / 100ps

module testbench
    import kdb_pkg::*;
();

    localparam int      NUM_KEYS        = 1024;
    localparam int      NUM_PHASES      = 8;
    localparam int      ITEMS_PER_PHASE = 150;
    localparam int      POOL_SIZE       = 6;
    localparam int      LONG_HOLD       = 300;
    localparam int      MAX_REPORTS     = 50;
    localparam int      DISABLED_PHASE  = 5;
    localparam longint  TIMEOUT_NS      = 5_000_000;
    localparam ts_t     STALE_GAP_NS    = 63'd5_000_000_000;
    localparam ts_t     MS_TO_NS        = 63'd1_000_000;
    localparam win_t    WINDOW_LIMIT_MS = 9'd500;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_SLOT0 + CFG_IDX_W'(CFG_SLOT_REGS);

    typedef enum int {READY_ALWAYS, READY_COIN, READY_PATTERN, READY_SPARSE} ready_mode_t;

    // Expected result of one item.
    typedef struct packed {
        logic        drop;
        logic [31:0] total;
    } verdict_t;

    // One row of the directed table: a register write or a key event.
    typedef struct {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        slot_t                value;
        key_t                 code;
        logic                 down;
        logic                 rep;
        ts_t                  ts;
        logic                 pinned;
        verdict_t             pinned_v;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [79:0]          s_tdata;   // event_code[9:0], time_ns[72:10], zero fill
    logic [1:0]           s_tuser;   // key_pressed[0], auto_repeat[1]
    logic                 m_tvalid;
    logic                 m_tready;
    logic [31:0]          m_tdata;   // drops_total[31:0]
    logic [0:0]           m_tuser;   // drop_event[0]
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SLOT_W-1:0]    cfg_wdata;

    // Shadow copy of the debounce state and configuration.
    key_flags_t key_flags [NUM_KEYS];
    ts_t        press_at [NUM_KEYS];
    ts_t        release_at [NUM_KEYS];
    ts_t        last_seen_at [NUM_KEYS];
    logic       owner_valid;
    key_t       owner_code;
    logic [31:0] drop_tally;
    logic       filt_on;
    win_t       gwin_ms;
    slot_t      slots [CFG_SLOT_REGS];

    verdict_t   expected_verdicts[$];
    int         err_count;
    int         items_sent;
    int         burst_left;
    bit         hold_req;
    ts_t        clock_ns;
    key_t       key_pool [POOL_SIZE];

    per_key_keyboard_debounce_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Windows above the limit fall back to a zero window.
    function automatic win_t bounded_ms(input win_t ms);
        return (ms > WINDOW_LIMIT_MS) ? win_t'(0) : ms;
    endfunction

    function automatic slot_t make_slot(input logic valid, input key_t code, input win_t ms);
        return {valid, code, ms};
    endfunction

    // Window values that sit on and around the interesting boundaries.
    function automatic win_t pick_window();
        case ($urandom_range(0, 9))
            0: return 9'd0;
            1: return 9'd1;
            2: return 9'd5;
            3: return 9'd20;
            4: return 9'd50;
            5: return 9'd100;
            6: return 9'd500;
            7: return 9'd501;
            8: return 9'd511;
            default: return win_t'($urandom_range(0, 511));
        endcase
    endfunction

    function automatic void forget_key(input key_t code);
        key_flags[code] = '0;
        if (owner_valid && owner_code == code)
            owner_valid = 1'b0;
    endfunction

    // Judge one key event against the shadow history and update it.
    function automatic verdict_t judge_key_event(input key_t code, input logic down,
                                                 input logic rep, input ts_t ts);
        verdict_t   v;
        key_flags_t f;
        win_t       ms;
        ts_t        win_ns;
        logic       hit;
        int         i;
        v.drop = 1'b0;
        if (!filt_on)
        begin
            forget_key(code);
        end
        else
        begin
            // A timestamp that runs backwards or a long silence clears the key.
            f = key_flags[code];
            if (f.ev && (ts < last_seen_at[code] || ts - last_seen_at[code] > STALE_GAP_NS))
                forget_key(code);
            f = key_flags[code];
            if (!down)
            begin
                if (f.held)
                begin
                    key_flags[code].held = 1'b0;
                    key_flags[code].rel  = 1'b1;
                    release_at[code]     = ts;
                end
            end
            else if (rep)
            begin
                key_flags[code].held = 1'b1;
            end
            else
            begin
                // First matching valid slot wins, else the global window.
                ms  = gwin_ms;
                hit = 1'b0;
                for (i = 0; i < CFG_SLOT_REGS; i++)
                begin
                    if (!hit && slots[i][SLOT_VALID_BIT] &&
                        slots[i][SLOT_CODE_LSB +: KEY_W] == code)
                    begin
                        hit = 1'b1;
                        ms  = bounded_ms(slots[i][WIN_W-1:0]);
                    end
                end
                win_ns = ts_t'(ms) * MS_TO_NS;
                if (win_ns != 0 && f.held && f.prs && ts >= press_at[code] &&
                    ts - press_at[code] < win_ns)
                begin
                    v.drop = 1'b1;
                end
                else if (win_ns != 0 && f.rel && owner_valid && owner_code == code &&
                         ts >= release_at[code] && ts - release_at[code] < win_ns)
                begin
                    v.drop = 1'b1;
                end
                else
                begin
                    key_flags[code].held = 1'b1;
                    key_flags[code].prs  = 1'b1;
                    press_at[code]       = ts;
                    owner_valid          = 1'b1;
                    owner_code           = code;
                end
            end
            key_flags[code].ev = 1'b1;
            last_seen_at[code] = ts;
            if (v.drop)
                drop_tally = drop_tally + 32'd1;
        end
        v.total = drop_tally;
        return v;
    endfunction

    function automatic stim_row_t key_row(input key_t code, input logic down, input logic rep,
                                          input ts_t ts);
        stim_row_t r;
        r.is_cfg   = 1'b0;
        r.idx      = '0;
        r.value    = '0;
        r.code     = code;
        r.down     = down;
        r.rep      = rep;
        r.ts       = ts;
        r.pinned   = 1'b0;
        r.pinned_v = '0;
        return r;
    endfunction

    function automatic stim_row_t pinned_row(input key_t code, input logic down, input logic rep,
                                             input ts_t ts, input logic drop,
                                             input logic [31:0] total);
        stim_row_t r;
        r                = key_row(code, down, rep, ts);
        r.pinned         = 1'b1;
        r.pinned_v.drop  = drop;
        r.pinned_v.total = total;
        return r;
    endfunction

    function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx, input slot_t value);
        stim_row_t r;
        r        = key_row('0, 1'b0, 1'b0, '0);
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.value  = value;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
    endtask

    // Register write; the caller lowers the enable after the last one.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input slot_t value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        if (idx == CFG_ENABLE)
            filt_on = value[0];
        else if (idx == CFG_GWIN)
            gwin_ms = bounded_ms(value[WIN_W-1:0]);
        else if (idx >= CFG_SLOT0 && idx < CFG_SPARE)
            slots[idx - CFG_SLOT0] = value;
    endtask

    // Offer one item in bursts with random gaps, then record its expected result.
    task automatic send_event(input key_t code, input logic down, input logic rep, input ts_t ts,
                              input logic pinned, input verdict_t pinned_v);
        int       gap;
        verdict_t v;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, ts, code};
        s_tuser  <= {rep, down};
        do @(posedge clk); while (!s_tready);
        v = judge_key_event(code, down, rep, ts);
        expected_verdicts.push_back(pinned ? pinned_v : v);
        items_sent++;
    endtask

    // Stop offering until every expected result has come out.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (expected_verdicts.size() != 0);
        repeat (2) @(posedge clk);
    endtask

    // A realistic keystroke: press, chatter, maybe autorepeat, release, chatter, maybe re-press.
    task automatic play_keystroke(input key_t code);
        int n;
        int k;
        clock_ns = clock_ns + ts_t'($urandom_range(0, 200_000_000));
        send_event(code, 1'b1, 1'b0, clock_ns, 1'b0, '0);
        n = $urandom_range(0, 3);
        for (k = 0; k < n; k++)
        begin
            clock_ns = clock_ns + ts_t'($urandom_range(0, 3_000_000));
            send_event(code, 1'($urandom_range(0, 1)), 1'b0, clock_ns, 1'b0, '0);
        end
        if ($urandom_range(0, 2) == 0)
        begin
            n = $urandom_range(1, 4);
            for (k = 0; k < n; k++)
            begin
                clock_ns = clock_ns + ts_t'($urandom_range(0, 40_000_000));
                send_event(code, 1'b1, 1'b1, clock_ns, 1'b0, '0);
            end
        end
        if ($urandom_range(0, 1) == 0)
            clock_ns = clock_ns + ts_t'($urandom_range(0, 30_000_000));
        else
            clock_ns = clock_ns + ts_t'($urandom_range(0, 600_000_000));
        send_event(code, 1'b0, 1'b0, clock_ns, 1'b0, '0);
        n = $urandom_range(0, 3);
        for (k = 0; k < n; k++)
        begin
            clock_ns = clock_ns + ts_t'($urandom_range(0, 3_000_000));
            send_event(code, 1'($urandom_range(0, 1)), 1'b0, clock_ns, 1'b0, '0);
        end
        if ($urandom_range(0, 1) == 0)
        begin
            clock_ns = clock_ns + ts_t'($urandom_range(0, 150_000_000));
            send_event(code, 1'b1, 1'b0, clock_ns, 1'b0, '0);
        end
    endtask

    // Result receiver: stall patterns in segments, plus one long hold-off on request.
    initial
    begin
        int          seg_left;
        int          hold_left;
        ready_mode_t mode;
        logic [7:0]  pat;
        seg_left  = 0;
        hold_left = 0;
        mode      = READY_ALWAYS;
        pat       = 8'hA5;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    mode     = ready_mode_t'($urandom_range(0, 3));
                    seg_left = $urandom_range(1, 60);
                    pat      = 8'($urandom_range(0, 255));
                end
                seg_left--;
                case (mode)
                    READY_ALWAYS:  m_tready <= 1'b1;
                    READY_COIN:    m_tready <= 1'($urandom_range(0, 1));
                    READY_PATTERN:
                    begin
                        m_tready <= pat[0];
                        pat = {pat[0], pat[7:1]};
                    end
                    default:       m_tready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        verdict_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_verdicts.size() == 0)
            begin
                report_mismatch("result with no item pending", 64'(m_tdata), 64'd0);
            end
            else
            begin
                e = expected_verdicts.pop_front();
                if (m_tuser[0] !== e.drop)
                    report_mismatch("drop_event", 64'(m_tuser), 64'(e.drop));
                if (m_tdata !== e.total)
                    report_mismatch("drops_total", 64'(m_tdata), 64'(e.total));
            end
        end
    end

    // Run limit.
    initial
    begin
        #(TIMEOUT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    // Main sequence: reset, directed table, then randomized phases.
    initial
    begin
        stim_row_t dir_tab[$];
        bit        cfg_open;
        bit        paused;
        int        phase;
        int        goal;
        int        pick;
        int        i;
        slot_t     gwin_val;

        for (i = 0; i < NUM_KEYS; i++)
        begin
            key_flags[i]    = '0;
            press_at[i]     = '0;
            release_at[i]   = '0;
            last_seen_at[i] = '0;
        end
        for (i = 0; i < CFG_SLOT_REGS; i++)
            slots[i] = '0;
        owner_valid = 1'b0;
        owner_code  = '0;
        drop_tally  = '0;
        filt_on     = 1'b0;
        gwin_ms     = '0;
        err_count   = 0;
        items_sent  = 0;
        burst_left  = 0;
        hold_req    = 1'b0;
        clock_ns    = 63'd1_000_000_000;

        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Filter off after reset: everything passes and nothing is counted.
        dir_tab.push_back(pinned_row(10'd0, 1'b1, 1'b0, 63'd0, 1'b0, 32'd0));
        dir_tab.push_back(pinned_row(10'd1023, 1'b0, 1'b0, 63'h7FFF_FFFF_FFFF_FFFF, 1'b0, 32'd0));
        dir_tab.push_back(pinned_row(10'd1023, 1'b1, 1'b1, 63'h7FFF_FFFF_FFFF_FFFF, 1'b0, 32'd0));
        dir_tab.push_back(pinned_row(10'h155, 1'b1, 1'b0, 63'h2AAA_AAAA_AAAA_AAAA, 1'b0, 32'd0));
        dir_tab.push_back(pinned_row(10'h2AA, 1'b0, 1'b1, 63'h5555_5555_5555_5555, 1'b0, 32'd0));
        // Enable with a 20 ms global window and a mix of slots.
        dir_tab.push_back(reg_row(CFG_ENABLE, 20'd1));
        dir_tab.push_back(reg_row(CFG_GWIN, 20'd20));
        dir_tab.push_back(reg_row(CFG_SLOT0, make_slot(1'b1, 10'd7, 9'd0)));
        dir_tab.push_back(reg_row(CFG_SLOT0 + 3'd1, make_slot(1'b1, 10'd9, 9'd501)));
        dir_tab.push_back(reg_row(CFG_SLOT0 + 3'd2, make_slot(1'b1, 10'd5, 9'd100)));
        dir_tab.push_back(reg_row(CFG_SLOT0 + 3'd3, make_slot(1'b0, 10'd5, 9'd3)));
        dir_tab.push_back(reg_row(CFG_SPARE, 20'hFFFFF));
        // Press, chatter within the held window, autorepeat, release, early re-press.
        dir_tab.push_back(key_row(10'd5, 1'b1, 1'b0, 63'd1_000_000_000));
        dir_tab.push_back(key_row(10'd5, 1'b1, 1'b0, 63'd1_001_000_000));
        dir_tab.push_back(key_row(10'd5, 1'b1, 1'b1, 63'd1_002_000_000));
        dir_tab.push_back(key_row(10'd5, 1'b0, 1'b0, 63'd1_050_000_000));
        dir_tab.push_back(key_row(10'd5, 1'b1, 1'b0, 63'd1_060_000_000));
        dir_tab.push_back(key_row(10'd5, 1'b1, 1'b0, 63'd1_200_000_000));
        // Zero-window slot, and a slot whose window is out of range.
        dir_tab.push_back(key_row(10'd7, 1'b1, 1'b0, 63'd1_201_000_000));
        dir_tab.push_back(key_row(10'd7, 1'b1, 1'b0, 63'd1_201_000_001));
        dir_tab.push_back(key_row(10'd9, 1'b1, 1'b0, 63'd1_300_000_000));
        dir_tab.push_back(key_row(10'd9, 1'b1, 1'b0, 63'd1_300_500_000));
        // Release of a key that is not held.
        dir_tab.push_back(key_row(10'd12, 1'b0, 1'b0, 63'd1_400_000_000));
        // Backward timestamp, then a gap beyond the stale limit.
        dir_tab.push_back(key_row(10'd5, 1'b1, 1'b0, 63'd10));
        dir_tab.push_back(key_row(10'd5, 1'b1, 1'b0, 63'd6_000_000_100));
        // Re-press after release while another key was accepted last.
        dir_tab.push_back(key_row(10'd20, 1'b1, 1'b0, 63'd6_100_000_000));
        dir_tab.push_back(key_row(10'd21, 1'b1, 1'b0, 63'd6_101_000_000));
        dir_tab.push_back(key_row(10'd20, 1'b0, 1'b0, 63'd6_102_000_000));
        dir_tab.push_back(key_row(10'd20, 1'b1, 1'b0, 63'd6_103_000_000));
        dir_tab.push_back(key_row(10'd21, 1'b1, 1'b0, 63'd6_103_500_000));
        // Disabling clears the touched key and passes the item.
        dir_tab.push_back(reg_row(CFG_ENABLE, 20'd0));
        dir_tab.push_back(key_row(10'd21, 1'b1, 1'b0, 63'd6_104_000_000));

        cfg_open = 1'b0;
        foreach (dir_tab[i])
        begin
            if (dir_tab[i].is_cfg)
            begin
                if (!cfg_open)
                begin
                    drain_results();
                    cfg_open = 1'b1;
                end
                cfg_write(dir_tab[i].idx, dir_tab[i].value);
            end
            else
            begin
                if (cfg_open)
                begin
                    cfg_we  <= 1'b0;
                    cfg_open = 1'b0;
                end
                send_event(dir_tab[i].code, dir_tab[i].down, dir_tab[i].rep, dir_tab[i].ts,
                           dir_tab[i].pinned, dir_tab[i].pinned_v);
            end
        end

        // Random phases, each with its own key pool and register settings.
        paused = 1'b0;
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            drain_results();
            for (i = 0; i < POOL_SIZE; i++)
                key_pool[i] = key_t'($urandom_range(0, NUM_KEYS - 1));
            case (phase)
                0: gwin_val = 20'd20;
                1: gwin_val = 20'd0;
                2: gwin_val = 20'd500;
                3: gwin_val = 20'd511;
                4: gwin_val = 20'd5;
                5: gwin_val = 20'd100;
                6: gwin_val = 20'd501;
                default: gwin_val = slot_t'($urandom_range(0, 20'hFFFFF));
            endcase
            cfg_write(CFG_ENABLE, (phase == DISABLED_PHASE) ? 20'd0 : 20'hFFFFF);
            cfg_write(CFG_GWIN, gwin_val);
            for (i = 0; i < CFG_SLOT_REGS; i++)
                cfg_write(CFG_SLOT0 + CFG_IDX_W'(i),
                          make_slot(1'($urandom_range(0, 1)),
                                    key_pool[$urandom_range(0, POOL_SIZE - 1)], pick_window()));
            if ($urandom_range(0, 1) == 0)
                cfg_write(CFG_SPARE + CFG_IDX_W'($urandom_range(0, 1)),
                          slot_t'($urandom_range(0, 20'hFFFFF)));
            cfg_we <= 1'b0;

            // The receiver holds off long enough for the core to stall its input.
            if (phase == 1)
                hold_req = 1'b1;

            goal = items_sent + ITEMS_PER_PHASE;
            while (items_sent < goal)
            begin
                if (phase == 2 && !paused && items_sent >= goal - ITEMS_PER_PHASE / 2)
                begin
                    drain_results();
                    paused = 1'b1;
                end
                pick = $urandom_range(0, 99);
                if (pick < 75)
                begin
                    play_keystroke(key_pool[$urandom_range(0, POOL_SIZE - 1)]);
                end
                else if (pick < 90)
                begin
                    clock_ns = clock_ns + ts_t'($urandom_range(0, 10_000_000));
                    send_event(key_t'($urandom_range(0, NUM_KEYS - 1)),
                               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                               ($urandom_range(0, 3) == 0) ? ts_t'({$urandom, $urandom})
                                                           : clock_ns,
                               1'b0, '0);
                end
                else
                begin
                    // Disturb the time base: step back, jump past the stale limit, or anywhere.
                    case ($urandom_range(0, 2))
                        0: clock_ns = clock_ns - ts_t'($urandom_range(0, 2_000_000_000));
                        1: clock_ns = clock_ns + STALE_GAP_NS
                                      + ts_t'($urandom_range(1, 1_000_000_000));
                        default: clock_ns = ts_t'({$urandom, $urandom});
                    endcase
                end
            end
        end

        drain_results();
        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
